>>> rtl/bgcd_pkg.sv
package bgcd_pkg;

	// Width of the operand and divisor fields on the ports.
	localparam int unsigned IO_WIDTH = 64;

	typedef struct packed {
		logic [IO_WIDTH-1:0] operand_a;
		logic [IO_WIDTH-1:0] operand_b;
	} bgcd_req_t;

	typedef struct packed {
		logic [IO_WIDTH-1:0] divisor;
		logic                zero_operand;
	} bgcd_rsp_t;

	// Step commands from the sequencer to the datapath.
	typedef struct packed {
		logic load;
		logic shift_both;
		logic shift_a;
		logic shift_b;
		logic sub;
		logic finish;
	} bgcd_ctrl_t;

	// Datapath flags that steer the sequencer.
	typedef struct packed {
		logic zero_in;
		logic a_odd;
		logic b_odd;
		logic diff_zero;
	} bgcd_stat_t;

endpackage

>>> rtl/binary_gcd.sv
// A request with a zero operand goes from idle straight to the done state, where the result
// is registered; otherwise the run grows with each shared halving, each stripped zero and
// each subtraction, all taken one at a time by the single subtract/halve unit.
// Throughput: one request at a time; busy stays high until the result strobe, and the next
// request may be taken in the strobe cycle. The receiver cannot stall the result.
// Reset: arst_n asynchronously returns the sequencer to idle and clears the result strobe.
module binary_gcd import bgcd_pkg::*; #(
	parameter int unsigned DATA_WIDTH = 64
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	output logic      busy,
	input  bgcd_req_t request,
	output logic      done,
	output bgcd_rsp_t result
);

	// The sequencer walks the method in four phases: halving both operands while both are
	// even (counting the shared twos), stripping leftover zeros from either one, forming
	// the absolute difference and writing it back, halved, over the larger operand, and finally
	// shifting the survivor back up by the shared twos. The datapath holds both operands
	// and the shared-twos count, and the single subtractor that forms the difference.

	bgcd_ctrl_t ctrl;
	bgcd_stat_t stat;

	bgcd_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.ctrl   (ctrl),
		.busy   (busy)
	);

	bgcd_dp #(
		.DATA_WIDTH (DATA_WIDTH)
	) u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.request (request),
		.ctrl    (ctrl),
		.stat    (stat),
		.result  (result),
		.done    (done)
	);

	// The strobe only appears once the sequencer has returned to idle.
	assert property (@(posedge clk) disable iff (!arst_n) done |-> !busy)
		else $error("result strobe while busy");

	// A taken request always occupies the block on the next cycle.
	assert property (@(posedge clk) disable iff (!arst_n) (start && !busy) |=> busy)
		else $error("request taken but block not busy");

	// Every end of work is marked by a result strobe.
	assert property (@(posedge clk) disable iff (!arst_n) $fell(busy) |-> done)
		else $error("work ended without a result");

	// A zero operand must report a zero divisor.
	assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.zero_operand) |-> (result.divisor == '0))
		else $error("zero operand with nonzero divisor");

endmodule

>>> rtl/bgcd_dp.sv
module bgcd_dp import bgcd_pkg::*; #(
	parameter int unsigned DATA_WIDTH = 64
) (
	input  logic       clk,
	input  logic       arst_n,
	input  bgcd_req_t  request,
	input  bgcd_ctrl_t ctrl,
	output bgcd_stat_t stat,
	output bgcd_rsp_t  result,
	output logic       done
);

	localparam int unsigned SHW = $clog2(DATA_WIDTH);

	logic [DATA_WIDTH-1:0] a_q, b_q;
	logic [SHW-1:0]        sh_q;
	logic                  err_q;
	bgcd_rsp_t             result_q;
	logic                  done_q;

	logic [DATA_WIDTH-1:0] in_a, in_b, diff;
	logic                  a_ge_b;

	assign in_a = request.operand_a[DATA_WIDTH-1:0];
	assign in_b = request.operand_b[DATA_WIDTH-1:0];

	// The shared subtract unit: absolute difference of the two operands.
	assign a_ge_b = (a_q >= b_q);
	assign diff   = a_ge_b ? (a_q - b_q) : (b_q - a_q);

	assign stat.zero_in   = (in_a == '0) || (in_b == '0);
	assign stat.a_odd     = a_q[0];
	assign stat.b_odd     = b_q[0];
	assign stat.diff_zero = (diff == '0);

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			a_q   <= in_a;
			b_q   <= in_b;
			sh_q  <= '0;
			err_q <= (in_a == '0) || (in_b == '0);
		end else if (ctrl.shift_both) begin
			a_q  <= a_q >> 1;
			b_q  <= b_q >> 1;
			sh_q <= sh_q + SHW'(1);
		end else if (ctrl.shift_a) begin
			a_q <= a_q >> 1;
		end else if (ctrl.shift_b) begin
			b_q <= b_q >> 1;
		end else if (ctrl.sub) begin
			// The difference of two odd values is even, so one halving is free.
			if (a_ge_b) begin
				a_q <= diff >> 1;
			end else begin
				b_q <= diff >> 1;
			end
		end
		if (ctrl.finish) begin
			result_q.divisor      <= err_q ? '0 : IO_WIDTH'(a_q << sh_q);
			result_q.zero_operand <= err_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= ctrl.finish;
		end
	end

	assign result = result_q;
	assign done   = done_q;

endmodule

>>> rtl/bgcd_seq.sv
module bgcd_seq import bgcd_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	input  bgcd_stat_t stat,
	output bgcd_ctrl_t ctrl,
	output logic       busy
);

	typedef enum logic [4:0] {
		S_IDLE  = 5'b00001,
		S_TWOS  = 5'b00010,
		S_STRIP = 5'b00100,
		S_SUB   = 5'b01000,
		S_DONE  = 5'b10000
	} state_t;

	state_t state_q, state_d;

	always_comb begin
		state_d = state_q;
		ctrl    = '0;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					ctrl.load = 1'b1;
					state_d   = stat.zero_in ? S_DONE : S_TWOS;
				end
			end
			S_TWOS: begin
				if (!stat.a_odd && !stat.b_odd) begin
					ctrl.shift_both = 1'b1;
				end else begin
					state_d = S_STRIP;
				end
			end
			S_STRIP: begin
				if (!stat.a_odd) begin
					ctrl.shift_a = 1'b1;
				end else if (!stat.b_odd) begin
					ctrl.shift_b = 1'b1;
				end else begin
					state_d = S_SUB;
				end
			end
			S_SUB: begin
				if (stat.diff_zero) begin
					state_d = S_DONE;
				end else begin
					ctrl.sub = 1'b1;
					state_d  = S_STRIP;
				end
			end
			S_DONE: begin
				ctrl.finish = 1'b1;
				state_d     = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign busy = (state_q != S_IDLE);

endmodule

>>> dv/binary_gcd_tb.sv
module binary_gcd_tb import bgcd_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned GCD_WIDTH = 64;
	localparam int CLK_HALF = 5;
	localparam int RESET_CYCLES = 8;
	// Extra wait after the final drain, to cover any tail of work still in
	// flight after the last result.
	localparam int SETTLE_CYCLES = 2 * GCD_WIDTH + 8;
	localparam int RANDOM_REQUESTS = 880;
	localparam logic [IO_WIDTH-1:0] ALL_ONES = {IO_WIDTH{1'b1}};

	// Keeps the expected divisors of accepted requests in order and compares
	// each result strobe against the oldest one.
	class gcd_scoreboard;
		bgcd_rsp_t expected_gcds[$];
		int unsigned requests;
		int unsigned zero_requests;
		int unsigned shared_factor;
		int unsigned checked;
		int unsigned failures;

		// Stein's method on the low GCD_WIDTH bits: pull out the common twos,
		// make both odd, then keep replacing the larger one by the odd part of
		// the difference until the two meet.
		function bgcd_rsp_t compute_gcd(bgcd_req_t req);
			logic [IO_WIDTH-1:0] keep;
			logic [IO_WIDTH-1:0] a;
			logic [IO_WIDTH-1:0] b;
			logic [IO_WIDTH-1:0] diff;
			int unsigned twos;
			bgcd_rsp_t rsp;
			keep = ALL_ONES >> (IO_WIDTH - GCD_WIDTH);
			a = req.operand_a & keep;
			b = req.operand_b & keep;
			twos = 0;
			rsp = '0;
			if (a == 0 || b == 0) begin
				rsp.zero_operand = 1'b1;
				return rsp;
			end
			while (!a[0] && !b[0]) begin
				a >>= 1;
				b >>= 1;
				twos++;
			end
			while (!a[0]) a >>= 1;
			while (!b[0]) b >>= 1;
			while (a != b) begin
				diff = (a > b) ? a - b : b - a;
				while (!diff[0]) diff >>= 1;
				if (a > b) a = diff;
				else b = diff;
			end
			rsp.divisor = (a << twos) & keep;
			return rsp;
		endfunction

		function void note(bgcd_req_t req);
			bgcd_rsp_t want;
			want = compute_gcd(req);
			expected_gcds.push_back(want);
			requests++;
			if (want.zero_operand) zero_requests++;
			else if (want.divisor > 1) shared_factor++;
		endfunction

		function void check(bgcd_rsp_t got);
			bgcd_rsp_t want;
			if (expected_gcds.size() == 0) begin
				$error("unexpected result: divisor %h zero_operand %b",
					got.divisor, got.zero_operand);
				failures++;
				return;
			end
			want = expected_gcds.pop_front();
			checked++;
			if (got.divisor !== want.divisor) begin
				$error("divisor: expected %h, got %h", want.divisor, got.divisor);
				failures++;
			end
			if (got.zero_operand !== want.zero_operand) begin
				$error("zero_operand: expected %b, got %b",
					want.zero_operand, got.zero_operand);
				failures++;
			end
		endfunction

		function int unsigned pending();
			return expected_gcds.size();
		endfunction
	endclass

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      start = 1'b0;
	logic      busy;
	bgcd_req_t request = '0;
	logic      done;
	bgcd_rsp_t result;

	gcd_scoreboard sb = new();

	binary_gcd #(
		.DATA_WIDTH(GCD_WIDTH)
	) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.request(request),
		.done   (done),
		.result (result)
	);

	always #CLK_HALF clk = ~clk;

	// Both sides are sampled at the rising edge, before the block's own
	// registers update, so what is seen here is what the edge acts on. A
	// result strobe is retired before a request in the same edge is noted;
	// the block never answers in the cycle it takes a request.
	always @(posedge clk) begin
		if (arst_n) begin
			if ($isunknown(done) || $isunknown(busy)) begin
				$error("done or busy unknown: done %b busy %b", done, busy);
				sb.failures++;
			end
			if (done) sb.check(result);
			if (start && !busy) sb.note(request);
		end
	end

	// Fixed-time limit on the whole run, well beyond the slowest legal run of
	// every request at full latency with the longest sender gaps.
	initial begin
		#(2 * CLK_HALF * 1_000_000);
		$error("run timed out with %0d results outstanding", sb.pending());
		$display("CHECKS FAILED");
		$finish;
	end

	function automatic logic [IO_WIDTH-1:0] rand_bits(int unsigned n);
		logic [IO_WIDTH-1:0] v;
		v = {$urandom, $urandom};
		return (n >= IO_WIDTH) ? v : (v >> (IO_WIDTH - n));
	endfunction

	function automatic bgcd_req_t pair(logic [IO_WIDTH-1:0] a, logic [IO_WIDTH-1:0] b);
		bgcd_req_t r;
		r.operand_a = a;
		r.operand_b = b;
		return r;
	endfunction

	// Called at a rising edge. Start is raised (or simply kept high in a burst)
	// and held until an edge sees busy low, which is the edge that takes the
	// request; the task returns in that same time step.
	task automatic push(bgcd_req_t r);
		start <= 1'b1;
		request <= r;
		do @(posedge clk); while (busy);
	endtask

	task automatic pause(int unsigned cycles);
		start <= 1'b0;
		repeat (cycles) @(posedge clk);
	endtask

	// Holds off until every request taken so far has been answered. The first
	// edge also lets the monitor note a request taken in the current step.
	task automatic drain();
		start <= 1'b0;
		do @(posedge clk); while (sb.pending() != 0);
	endtask

	initial begin
		bgcd_req_t corner_reqs[$];
		bgcd_req_t r;
		logic [IO_WIDTH-1:0] g;
		logic [IO_WIDTH-1:0] x;
		logic [IO_WIDTH-1:0] y;
		int unsigned glen;
		int unsigned kind;
		int unsigned burst;
		int unsigned sent;

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed requests: zero operands on either side and both, the
		// extremes of the operand range, heavy shared powers of two, operand
		// order swapped, equal operands, and a pair of large consecutive
		// Fibonacci numbers that keeps the subtract loop going for a long time.
		corner_reqs.push_back(pair(0, 0));
		corner_reqs.push_back(pair(0, 1));
		corner_reqs.push_back(pair(ALL_ONES, 0));
		corner_reqs.push_back(pair(1, 1));
		corner_reqs.push_back(pair(ALL_ONES, ALL_ONES));
		corner_reqs.push_back(pair(ALL_ONES, 1));
		corner_reqs.push_back(pair(1, ALL_ONES));
		corner_reqs.push_back(pair(ALL_ONES, ALL_ONES - 1));
		corner_reqs.push_back(pair(ALL_ONES - 1, 2));
		corner_reqs.push_back(pair(64'h8000_0000_0000_0000, 64'h8000_0000_0000_0000));
		corner_reqs.push_back(pair(64'h8000_0000_0000_0000, 1));
		corner_reqs.push_back(pair(64'h8000_0000_0000_0000, 64'hC000_0000_0000_0000));
		corner_reqs.push_back(pair(64'h4000_0000_0000_0000, 64'h0000_0000_0000_0003));
		corner_reqs.push_back(pair(48, 18));
		corner_reqs.push_back(pair(18, 48));
		corner_reqs.push_back(pair(6, 6));
		corner_reqs.push_back(pair(64'h8000_0000_0000_0001, 64'h8000_0000_0000_0001));
		corner_reqs.push_back(pair(64'd7540113804746346429, 64'd4660046610375530309));
		corner_reqs.push_back(pair(64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555));
		corner_reqs.push_back(pair(64'h0000_0300_0000_0000, 64'h0000_0000_0090_0000));
		corner_reqs.push_back(pair(64'd1000000007 * 64'd998244353, 64'd1000000007 * 64'd3));
		foreach (corner_reqs[i]) push(corner_reqs[i]);
		drain();

		// Random requests in bursts: inside a burst start stays high, so the
		// next request is taken in the strobe cycle of the previous one; the
		// gaps between bursts range from none at all to longer than a request's
		// whole run, so they land on every stage of the block's work.
		sent = 0;
		while (sent < RANDOM_REQUESTS) begin
			burst = $urandom_range(1, 24);
			repeat (burst) begin
				kind = $urandom_range(0, 99);
				if (kind < 3) begin
					// A zero on one side or both.
					x = ($urandom_range(0, 1) == 0) ? '0 : rand_bits(64);
					y = ($urandom_range(0, 1) == 0) ? '0 : rand_bits(64);
					if (x != 0 && y != 0) x = '0;
					r = pair(x, y);
				end else if (kind < 33) begin
					r = pair(rand_bits(64), rand_bits(64));
				end else if (kind < 73) begin
					// A known common factor, odd part times a power of two,
					// sized so that both products still fit the operand width.
					g = (rand_bits($urandom_range(1, 40)) | 1) << $urandom_range(0, 16);
					glen = $clog2(g + 1);
					x = rand_bits(IO_WIDTH - glen) | 1;
					y = rand_bits($urandom_range(1, IO_WIDTH - glen)) | 1;
					r = ($urandom_range(0, 1) == 0) ? pair(g * x, g * y) : pair(g * y, g * x);
				end else if (kind < 88) begin
					r = pair(rand_bits($urandom_range(1, 16)), rand_bits($urandom_range(1, 16)));
				end else if (kind < 95) begin
					// Many trailing zeros on both sides.
					r = pair(rand_bits(64) << $urandom_range(0, 63),
						rand_bits(64) << $urandom_range(0, 63));
				end else begin
					x = rand_bits($urandom_range(1, 64));
					r = pair(x, x);
				end
				push(r);
				sent++;
			end
			if (sent % 150 < burst) begin
				drain();
			end else begin
				case ($urandom_range(0, 3))
					0: pause($urandom_range(1, 3));
					1: pause($urandom_range(4, 40));
					2: pause($urandom_range(41, 160));
					default: ;
				endcase
			end
		end

		drain();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (sb.pending() != 0) begin
			$error("%0d expected results never arrived", sb.pending());
			sb.failures++;
		end

		$display("Run covered %0d requests: %0d with a zero operand, %0d with a divisor above one.",
			sb.requests, sb.zero_requests, sb.shared_factor);
		$display("%0d results compared, %0d mismatches.", sb.checked, sb.failures);
		if (sb.failures == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule

>>> files.f
rtl/bgcd_pkg.sv
rtl/bgcd_dp.sv
rtl/bgcd_seq.sv
rtl/binary_gcd.sv
dv/binary_gcd_tb.sv
